[sv/djc_pkg.sv]
package djc_pkg;

    localparam int DEPTH_BITS    = 14;
    localparam int FRAC_BITS     = 16;
    localparam int IR_BITS       = 16;
    localparam int CHAN_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH_NEAR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH_SPAN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IR_FULL    = 2'd2;

    localparam logic [DEPTH_BITS-1:0] DEPTH_NEAR_RST = DEPTH_BITS'(200);
    localparam logic [DEPTH_BITS-1:0] DEPTH_SPAN_RST = DEPTH_BITS'(2100);
    localparam logic [IR_BITS-1:0]    IR_FULL_RST    = IR_BITS'(4500);

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth_near_mm;
        logic [DEPTH_BITS-1:0] depth_span_mm;
        logic [IR_BITS-1:0]    ir_full_scale;
    } djc_cfg_t;

    // One pixel on its way through the dividers.
    typedef struct packed {
        logic [DEPTH_BITS-1:0] t_rem;
        logic [FRAC_BITS-1:0]  t_quo;
        logic                  t_zero;
        logic                  t_one;
        logic [IR_BITS-1:0]    g_rem;
        logic [CHAN_BITS-1:0]  g_low;
        logic [CHAN_BITS-1:0]  g_quo;
        logic                  g_sat;
    } djc_div_t;

endpackage

[sv/djc_pixel_if.sv]
interface djc_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [djc_pkg::DEPTH_BITS-1:0] depth_mm;
    logic [djc_pkg::IR_BITS-1:0]    ir_value;

    modport source (output valid, output depth_mm, output ir_value, input ready);
    modport sink   (input valid, input depth_mm, input ir_value, output ready);
endinterface

[sv/djc_color_if.sv]
interface djc_color_if;
    logic                         valid;
    logic                         ready;
    logic [djc_pkg::CHAN_BITS-1:0] jet_red;
    logic [djc_pkg::CHAN_BITS-1:0] jet_green;
    logic [djc_pkg::CHAN_BITS-1:0] jet_blue;
    logic [djc_pkg::CHAN_BITS-1:0] ir_gray;

    modport source (output valid, output jet_red, output jet_green, output jet_blue,
                    output ir_gray, input ready);
    modport sink   (input valid, input jet_red, input jet_green, input jet_blue,
                    input ir_gray, output ready);
endinterface

[sv/depth_jet_and_ir_gray_colorizer.sv]
// Colors one pixel per clock while the output is not stalled: a JET false color
// for the depth sample and a gray level for the infrared value. A result passes
// through the front stage, 16 restoring-divider stages that produce one bit of
// the normalized depth per stage while the first 8 of them also divide the
// infrared value, the color-level stage and the output register. A stall at
// the output freezes the whole pipeline; pixel.ready is high whenever the output
// register is empty or being taken. Registers are written through
// cfg_we/cfg_index/cfg_data and must only change while no pixel is in flight.
module depth_jet_and_ir_gray_colorizer
(
    input  logic                                clk,
    input  logic                                rst_n,
    djc_pixel_if.sink                           pixel,
    djc_color_if.source                         color,
    input  logic                                cfg_we,
    input  logic [djc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [djc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int FB = djc_pkg::FRAC_BITS;
    localparam int CB = djc_pkg::CHAN_BITS;
    localparam int JW = FB + 4;

    localparam logic [1:0] K_RED   = 2'd3;
    localparam logic [1:0] K_GREEN = 2'd2;
    localparam logic [1:0] K_BLUE  = 2'd1;

    // clamp(1.5 - |4t - k|, 0, 1) in Q.FB
    function automatic logic [FB:0] jet_level(logic [FB:0] t, logic [1:0] k);
        logic signed [JW-1:0] d;
        logic signed [JW-1:0] v;
        d = $signed({1'b0, t, 2'b00}) - $signed({2'b00, k, {FB{1'b0}}});
        if (d < 0)
        begin
            d = -d;
        end
        v = $signed({3'b000, 2'b11, {(FB-1){1'b0}}}) - d;
        if (v < 0)
        begin
            v = '0;
        end
        else if (v > $signed({3'b000, 1'b1, {FB{1'b0}}}))
        begin
            v = $signed({3'b000, 1'b1, {FB{1'b0}}});
        end
        return v[FB:0];
    endfunction

    // (v * 255) >> FB
    function automatic logic [CB-1:0] scale255(logic [FB:0] v);
        logic [FB+CB:0] p;
        p = {v, {CB{1'b0}}} - {{CB{1'b0}}, v};
        return p[FB+CB-1:FB];
    endfunction

    djc_pkg::djc_cfg_t cfg_reg;
    logic              en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_near_mm <= djc_pkg::DEPTH_NEAR_RST;
            cfg_reg.depth_span_mm <= djc_pkg::DEPTH_SPAN_RST;
            cfg_reg.ir_full_scale <= djc_pkg::IR_FULL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                djc_pkg::CFG_DEPTH_NEAR:
                    cfg_reg.depth_near_mm <= cfg_data[djc_pkg::DEPTH_BITS-1:0];
                djc_pkg::CFG_DEPTH_SPAN:
                    cfg_reg.depth_span_mm <= cfg_data[djc_pkg::DEPTH_BITS-1:0];
                djc_pkg::CFG_IR_FULL:
                    cfg_reg.ir_full_scale <= cfg_data[djc_pkg::IR_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    logic color_valid_reg;
    assign en          = !color_valid_reg || color.ready;
    assign pixel.ready = en;

    // Front stage: offset, range flags, ir * 255.
    djc_pkg::djc_div_t                front_next;
    djc_pkg::djc_div_t                front_reg;
    logic                             front_valid_reg;
    logic [djc_pkg::DEPTH_BITS-1:0]   diff;
    logic [djc_pkg::IR_BITS+CB-1:0]   ir_prod;

    always_comb
    begin
        diff    = pixel.depth_mm - cfg_reg.depth_near_mm;
        ir_prod = {pixel.ir_value, {CB{1'b0}}} - {{CB{1'b0}}, pixel.ir_value};
        front_next.t_rem  = diff;
        front_next.t_quo  = '0;
        front_next.t_zero = (pixel.depth_mm == '0) || (pixel.depth_mm <= cfg_reg.depth_near_mm);
        front_next.t_one  = !front_next.t_zero && (diff >= cfg_reg.depth_span_mm);
        front_next.g_rem  = ir_prod[djc_pkg::IR_BITS+CB-1:CB];
        front_next.g_low  = ir_prod[CB-1:0];
        front_next.g_quo  = '0;
        front_next.g_sat  = pixel.ir_value >= cfg_reg.ir_full_scale;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            front_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg <= front_next;
        end
    end

    logic              div_valid;
    djc_pkg::djc_div_t div_data;

    djc_divpipe u_divpipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid_reg),
        .in_data   (front_reg),
        .cfg       (cfg_reg),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // Color level stage.
    logic [FB:0]   t_pos;
    logic [FB:0]   red_lvl_reg;
    logic [FB:0]   green_lvl_reg;
    logic [FB:0]   blue_lvl_reg;
    logic [CB-1:0] gray_reg;
    logic          j1_valid_reg;

    always_comb
    begin
        if (div_data.t_zero)
        begin
            t_pos = '0;
        end
        else if (div_data.t_one)
        begin
            t_pos = {1'b1, {FB{1'b0}}};
        end
        else
        begin
            t_pos = {1'b0, div_data.t_quo};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j1_valid_reg    <= 1'b0;
            color_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            j1_valid_reg    <= div_valid;
            color_valid_reg <= j1_valid_reg;
        end
    end

    logic [CB-1:0] red_reg;
    logic [CB-1:0] green_reg;
    logic [CB-1:0] blue_reg;
    logic [CB-1:0] ir_gray_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_lvl_reg   <= jet_level(t_pos, K_RED);
            green_lvl_reg <= jet_level(t_pos, K_GREEN);
            blue_lvl_reg  <= jet_level(t_pos, K_BLUE);
            gray_reg      <= div_data.g_sat ? {CB{1'b1}} : div_data.g_quo;
            red_reg       <= scale255(red_lvl_reg);
            green_reg     <= scale255(green_lvl_reg);
            blue_reg      <= scale255(blue_lvl_reg);
            ir_gray_reg   <= gray_reg;
        end
    end

    assign color.valid     = color_valid_reg;
    assign color.jet_red   = red_reg;
    assign color.jet_green = green_reg;
    assign color.jet_blue  = blue_reg;
    assign color.ir_gray   = ir_gray_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready |=> front_valid_reg)
        else $error("accepted item did not enter the front stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(j1_valid_reg) && $stable(red_lvl_reg) && $stable(gray_reg))
        else $error("color level stage moved during a stall");

    a_jet_shape: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid && color.jet_red != '0 && color.jet_blue != '0
            |-> color.jet_green == {CB{1'b1}})
        else $error("red and blue both lit without full green");

endmodule

[sv/djc_divpipe.sv]
module djc_divpipe
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  djc_pkg::djc_div_t in_data,
    input  djc_pkg::djc_cfg_t cfg,
    output logic              out_valid,
    output djc_pkg::djc_div_t out_data
);

    localparam int NDIV = djc_pkg::FRAC_BITS;

    // One restoring step for depth and, in the first stages, one for gray.
    function automatic djc_pkg::djc_div_t div_step(djc_pkg::djc_div_t src,
                                                   djc_pkg::djc_cfg_t c,
                                                   logic do_gray);
        djc_pkg::djc_div_t             nxt;
        logic [djc_pkg::DEPTH_BITS:0]  t_try;
        logic [djc_pkg::IR_BITS:0]     g_try;
        nxt   = src;
        t_try = {src.t_rem, 1'b0};
        if (t_try >= {1'b0, c.depth_span_mm})
        begin
            nxt.t_rem = djc_pkg::DEPTH_BITS'(t_try - {1'b0, c.depth_span_mm});
            nxt.t_quo = {src.t_quo[djc_pkg::FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            nxt.t_rem = t_try[djc_pkg::DEPTH_BITS-1:0];
            nxt.t_quo = {src.t_quo[djc_pkg::FRAC_BITS-2:0], 1'b0};
        end
        if (do_gray)
        begin
            g_try     = {src.g_rem, src.g_low[djc_pkg::CHAN_BITS-1]};
            nxt.g_low = {src.g_low[djc_pkg::CHAN_BITS-2:0], 1'b0};
            if (g_try >= {1'b0, c.ir_full_scale})
            begin
                nxt.g_rem = djc_pkg::IR_BITS'(g_try - {1'b0, c.ir_full_scale});
                nxt.g_quo = {src.g_quo[djc_pkg::CHAN_BITS-2:0], 1'b1};
            end
            else
            begin
                nxt.g_rem = g_try[djc_pkg::IR_BITS-1:0];
                nxt.g_quo = {src.g_quo[djc_pkg::CHAN_BITS-2:0], 1'b0};
            end
        end
        return nxt;
    endfunction

    djc_pkg::djc_div_t [NDIV-1:0] stage_reg;
    djc_pkg::djc_div_t [NDIV-1:0] stage_next;
    logic [NDIV-1:0]              valid_reg;
    logic [NDIV-1:0]              valid_next;

    always_comb
    begin
        stage_next[0] = div_step(in_data, cfg, 1'b1);
        valid_next[0] = in_valid;
        for (int s = 1; s < NDIV; s++)
        begin
            stage_next[s] = div_step(stage_reg[s-1], cfg, s < djc_pkg::CHAN_BITS);
            valid_next[s] = valid_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg[NDIV-1];
    assign out_data  = stage_reg[NDIV-1];

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam logic [djc_pkg::CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;
    localparam longint T_ONE       = longint'(1) << djc_pkg::FRAC_BITS;
    localparam int     QUIET_LIMIT = 4000;
    localparam int     HOLD_CYCLES = 120;
    localparam int     GAP_PCT     = 14;

    typedef struct packed {
        logic [djc_pkg::DEPTH_BITS-1:0] depth;
        logic [djc_pkg::IR_BITS-1:0]    ir;
    } pixel_t;

    typedef struct packed {
        logic [djc_pkg::CHAN_BITS-1:0] red;
        logic [djc_pkg::CHAN_BITS-1:0] green;
        logic [djc_pkg::CHAN_BITS-1:0] blue;
        logic [djc_pkg::CHAN_BITS-1:0] gray;
    } color_t;

    logic                              clk;
    logic                              rst_n = 1'b1;
    logic                              cfg_we;
    logic [djc_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [djc_pkg::CFG_DATA_BITS-1:0] cfg_data;

    djc_pixel_if pixel_bus();
    djc_color_if color_bus();

    depth_jet_and_ir_gray_colorizer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_bus),
        .color     (color_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies used for prediction
    logic [djc_pkg::DEPTH_BITS-1:0] near_mm;
    logic [djc_pkg::DEPTH_BITS-1:0] span_mm;
    logic [djc_pkg::IR_BITS-1:0]    full_scale;

    pixel_t pending_pixels[$];
    color_t expected_colors[$];
    pixel_t next_px;
    color_t want;

    bit src_gaps_on;
    bit snk_gaps_on;
    int hold_asked;
    int hold_served;
    int hold_left;
    int quiet_cycles;
    int n_errors;
    int n_pixels;
    int n_checked;
    int n_no_depth;
    int n_ir_sat;
    int n_settings;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [djc_pkg::CHAN_BITS-1:0] jet_level(longint t, longint k);
        longint d;
        longint v;
        d = 4 * t - k * T_ONE;
        if (d < 0)
            d = -d;
        v = (3 * T_ONE) / 2 - d;
        if (v < 0)
            v = 0;
        if (v > T_ONE)
            v = T_ONE;
        return djc_pkg::CHAN_BITS'((v * 255) >> djc_pkg::FRAC_BITS);
    endfunction

    function automatic color_t colorize_pixel(logic [djc_pkg::DEPTH_BITS-1:0] depth,
                                              logic [djc_pkg::IR_BITS-1:0] ir);
        color_t c;
        longint t;
        longint diff;
        // no depth and anything up to near sit at the blue end
        if (depth == 0 || depth <= near_mm)
            t = 0;
        else
        begin
            diff = longint'(depth) - longint'(near_mm);
            if (diff >= longint'(span_mm))
                t = T_ONE;
            else
                t = (diff << djc_pkg::FRAC_BITS) / longint'(span_mm);
        end
        c.red   = jet_level(t, 3);
        c.green = jet_level(t, 2);
        c.blue  = jet_level(t, 1);
        if (ir >= full_scale)
            c.gray = 8'd255;
        else
            c.gray = djc_pkg::CHAN_BITS'((longint'(ir) * 255) / longint'(full_scale));
        return c;
    endfunction

    // Sender: offer queued pixels, predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bus.valid    <= 1'b0;
            pixel_bus.depth_mm <= '0;
            pixel_bus.ir_value <= '0;
        end
        else
        begin
            if (pixel_bus.valid && pixel_bus.ready)
            begin
                expected_colors.push_back(colorize_pixel(pixel_bus.depth_mm,
                                                         pixel_bus.ir_value));
                n_pixels++;
                if (pixel_bus.depth_mm == 0)
                    n_no_depth++;
                if (pixel_bus.ir_value >= full_scale)
                    n_ir_sat++;
            end
            if (!pixel_bus.valid || pixel_bus.ready)
            begin
                if (pending_pixels.size() != 0 &&
                    !(src_gaps_on && $urandom_range(99) < GAP_PCT))
                begin
                    next_px = pending_pixels.pop_front();
                    pixel_bus.valid    <= 1'b1;
                    pixel_bus.depth_mm <= next_px.depth;
                    pixel_bus.ir_value <= next_px.ir;
                end
                else
                    pixel_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each color item against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_bus.ready <= 1'b0;
        else
        begin
            if (color_bus.valid && color_bus.ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("color item with no pixel waiting for it");
                    n_errors++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    n_checked++;
                    if (color_bus.jet_red !== want.red)
                    begin
                        $error("jet_red: expected %0d, got %0d", want.red, color_bus.jet_red);
                        n_errors++;
                    end
                    if (color_bus.jet_green !== want.green)
                    begin
                        $error("jet_green: expected %0d, got %0d",
                               want.green, color_bus.jet_green);
                        n_errors++;
                    end
                    if (color_bus.jet_blue !== want.blue)
                    begin
                        $error("jet_blue: expected %0d, got %0d", want.blue, color_bus.jet_blue);
                        n_errors++;
                    end
                    if (color_bus.ir_gray !== want.gray)
                    begin
                        $error("ir_gray: expected %0d, got %0d", want.gray, color_bus.ir_gray);
                        n_errors++;
                    end
                end
            end
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                color_bus.ready <= 1'b0;
            end
            else
                color_bus.ready <= !(snk_gaps_on && $urandom_range(99) < GAP_PCT);
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((pixel_bus.valid && pixel_bus.ready) || (color_bus.valid && color_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic set_register(input logic [djc_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [djc_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            djc_pkg::CFG_DEPTH_NEAR: near_mm    = data[djc_pkg::DEPTH_BITS-1:0];
            djc_pkg::CFG_DEPTH_SPAN: span_mm    = data[djc_pkg::DEPTH_BITS-1:0];
            djc_pkg::CFG_IR_FULL:    full_scale = data[djc_pkg::IR_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input int near_v, input int span_v, input int full_v);
        logic [1:0] junk;
        // upper bits above the depth width must be dropped
        junk = 2'($urandom_range(3));
        set_register(djc_pkg::CFG_DEPTH_NEAR, {junk, djc_pkg::DEPTH_BITS'(near_v)});
        junk = 2'($urandom_range(3));
        set_register(djc_pkg::CFG_DEPTH_SPAN, {junk, djc_pkg::DEPTH_BITS'(span_v)});
        set_register(djc_pkg::CFG_IR_FULL, djc_pkg::IR_BITS'(full_v));
        n_settings++;
    endtask

    task automatic queue_pixel(input int depth, input int ir);
        pixel_t p;
        p.depth = djc_pkg::DEPTH_BITS'(depth);
        p.ir    = djc_pkg::IR_BITS'(ir);
        pending_pixels.push_back(p);
    endtask

    task automatic queue_random_pixels(input int count);
        int d;
        int ir;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0:       d = 0;
                1, 2:    d = $urandom_range(16383);
                default: d = int'(near_mm) + int'($urandom_range(int'(span_mm) + 4)) - 2;
            endcase
            if (d < 0)
                d = 0;
            if (d > 16383)
                d = 16383;
            case ($urandom_range(3))
                0:       ir = $urandom_range(65535);
                1:       ir = int'(full_scale) + int'($urandom_range(4)) - 2;
                default: ir = $urandom_range(int'(full_scale));
            endcase
            if (ir < 0)
                ir = 0;
            if (ir > 65535)
                ir = 65535;
            queue_pixel(d, ir);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_pixels.size() != 0 || pixel_bus.valid || expected_colors.size() != 0);
    endtask

    initial
    begin
        cfg_we      = 1'b0;
        cfg_index   = djc_pkg::CFG_DEPTH_NEAR;
        cfg_data    = '0;
        near_mm     = djc_pkg::DEPTH_NEAR_RST;
        span_mm     = djc_pkg::DEPTH_SPAN_RST;
        full_scale  = djc_pkg::IR_FULL_RST;
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: no depth, near edge, quarter points, far end
        queue_pixel(0, 0);
        queue_pixel(1, 65535);
        queue_pixel(200, 4499);
        queue_pixel(201, 4500);
        queue_pixel(725, 1);
        queue_pixel(1250, 2250);
        queue_pixel(1775, 4501);
        queue_pixel(2299, 17);
        queue_pixel(2300, 0);
        queue_pixel(16383, 65535);
        wait_drained();

        // smallest span and full scale
        set_all(0, 1, 1);
        set_register(CFG_UNMAPPED, 16'hFFFF);
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(2, 65535);
        queue_pixel(16383, 0);
        wait_drained();

        // largest near, span and full scale
        set_all(16383, 16383, 65535);
        queue_pixel(16383, 65535);
        queue_pixel(16382, 65534);
        queue_pixel(0, 0);
        queue_pixel(1, 32768);
        wait_drained();

        // zero span acts as a step, zero full scale saturates
        set_all(1000, 0, 0);
        queue_pixel(999, 0);
        queue_pixel(1000, 65535);
        queue_pixel(1001, 12345);
        queue_pixel(0, 1);
        wait_drained();

        // wide writes keep only the register width
        set_register(djc_pkg::CFG_DEPTH_NEAR, 16'hC0C8);
        set_register(djc_pkg::CFG_DEPTH_SPAN, 16'h4834);
        set_register(djc_pkg::CFG_IR_FULL, 16'h1194);
        set_register(CFG_UNMAPPED, 16'h0001);
        n_settings++;
        queue_pixel(200, 4500);
        queue_pixel(1250, 2250);
        queue_pixel(2300, 4499);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: set_all($urandom_range(1000), $urandom_range(500, 6000),
                           $urandom_range(1000, 20000));
                1: set_all($urandom_range(16383), $urandom_range(1, 64),
                           $urandom_range(1, 300));
                2: set_all($urandom_range(16383), $urandom_range(16383),
                           $urandom_range(65535));
                default: set_all($urandom_range(200), 16383, 65535);
            endcase
            src_gaps_on = (ph != 2 && ph != 5);
            snk_gaps_on = (ph != 5);
            // hold the receiver while the sender streams
            if (ph == 2)
                hold_asked++;
            queue_random_pixels(200);
            wait_drained();
        end

        repeat (25) @(posedge clk);
        $display("checked %0d of %0d pixels over %0d register settings", n_checked, n_pixels,
                 n_settings);
        $display("%0d pixels with no depth, %0d with saturated infrared, one long output hold",
                 n_no_depth, n_ir_sat);
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[filelist.f]
sv/djc_pkg.sv
sv/djc_pixel_if.sv
sv/djc_color_if.sv
sv/djc_divpipe.sv
sv/depth_jet_and_ir_gray_colorizer.sv
bench/tb.sv
